>>> hw/rtl/vqm_pkg.sv
// Shared types, constants and codes of the virtqueue descriptor ring manager.
`timescale 1ns / 1ps

package vqm_pkg;

   localparam int RING_SIZE = 128;
   localparam int IDX_W     = $clog2(RING_SIZE);
   localparam int TAG_WIDTH = 16;
   localparam int FREE_W    = 8;
   localparam int LEN_W     = 16;
   localparam int CNT_W     = 16;
   localparam int ADDR_W    = 4;
   localparam int DATA_W    = 32;

   localparam logic [LEN_W-1:0]  HDR_BYTES   = LEN_W'(12);
   localparam logic [FREE_W-1:0] FREE_RESET  = FREE_W'(RING_SIZE);
   localparam logic [LEN_W-1:0]  MAX_LEN_RST = LEN_W'(2048);

   localparam logic CMD_POST     = 1'b0;
   localparam logic CMD_COMPLETE = 1'b1;

   localparam logic [1:0] REG_MERGE   = 2'd0;
   localparam logic [1:0] REG_CHECKS  = 2'd1;
   localparam logic [1:0] REG_MAX_LEN = 2'd2;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_RING_FULL = 3'd1,
      ST_EMPTY     = 3'd2,
      ST_SHORT     = 3'd3,
      ST_GSO       = 3'd4,
      ST_CSUM      = 3'd5,
      ST_MERGED    = 3'd6,
      ST_OVERSIZE  = 3'd7
   } status_type;

   typedef struct packed {
      logic                 command;
      logic [15:0]          buffer_tag;
      logic [LEN_W-1:0]     post_len;
      logic [6:0]           used_id;
      logic [LEN_W-1:0]     used_len;
      logic [7:0]           seg_kind;
      logic [7:0]           header_flags;
      logic [CNT_W-1:0]     buffer_count;
   } req_type;

   typedef struct packed {
      logic [2:0]           status;
      logic [6:0]           desc_index;
      logic [LEN_W-1:0]     desc_len;
      logic [6:0]           ring_slot;
      logic [15:0]          avail_count;
      logic [15:0]          used_count;
      logic [15:0]          tag_out;
      logic [LEN_W-1:0]     payload_len;
      logic [FREE_W-1:0]    free_left;
   } rsp_type;

   typedef struct packed {
      logic                 merge_feature_on;
      logic                 header_checks_on;
      logic [LEN_W-1:0]     max_buffer_len;
   } cfg_type;

   typedef struct packed {
      logic launch;
      logic commit;
   } ctl_cmd_type;

endpackage

>>> hw/rtl/virtqueue_descriptor_ring_manager.sv
// Top level of the split virtqueue driver-side descriptor ring manager.
//
//   Channel   Direction  Handshake                   Payload
//   request   in         start, busy                 req_data (vqm_pkg::req_type)
//   result    out        rsp_valid (one-cycle pulse) rsp_data (vqm_pkg::rsp_type)
//   config    in/out     psel, penable, pwrite       paddr, pwdata, prdata, pready
//
// A transaction has an accept cycle and a commit cycle. The accept cycle issues
// the link and tag memory reads, the commit cycle writes the memories and
// updates the indices. The result strobe comes in the cycle after commit, when
// the next transaction may already be accepted; busy holds off new ones in commit.
// Synchronous reset takes effect at once; the link store reset image comes from
// per-entry valid bits, so no clearing pass is needed. Results cannot be stalled.
`timescale 1ns / 1ps

module virtqueue_descriptor_ring_manager (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  vqm_pkg::req_type              req_data,
   output logic                          rsp_valid,
   output vqm_pkg::rsp_type              rsp_data,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [vqm_pkg::ADDR_W-1:0]    paddr,
   input  logic [vqm_pkg::DATA_W-1:0]    pwdata,
   output logic [vqm_pkg::DATA_W-1:0]    prdata,
   output logic                          pready
);

   vqm_pkg::cfg_type     cfg;
   vqm_pkg::ctl_cmd_type cmd;

   vqm_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   vqm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .cmd       (cmd)
   );

   vqm_dp u_dp (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .cfg      (cfg),
      .req_data (req_data),
      .rsp_data (rsp_data)
   );

endmodule

>>> hw/rtl/vqm_csr.sv
// Configuration register file behind the APB-style port.
`timescale 1ns / 1ps

module vqm_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [vqm_pkg::ADDR_W-1:0]    paddr,
   input  logic [vqm_pkg::DATA_W-1:0]    pwdata,
   output logic [vqm_pkg::DATA_W-1:0]    prdata,
   output logic                          pready,
   output vqm_pkg::cfg_type              cfg
);

   vqm_pkg::cfg_type cfg_ff;
   logic [1:0]       reg_sel;
   logic             wr_en;

   assign reg_sel = paddr[3:2];
   assign wr_en   = psel && penable && pwrite;
   assign pready  = 1'b1;
   assign cfg     = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.merge_feature_on <= 1'b0;
         cfg_ff.header_checks_on <= 1'b1;
         cfg_ff.max_buffer_len   <= vqm_pkg::MAX_LEN_RST;
      end else if (wr_en) begin
         unique case (reg_sel)
            vqm_pkg::REG_MERGE:   cfg_ff.merge_feature_on <= pwdata[0];
            vqm_pkg::REG_CHECKS:  cfg_ff.header_checks_on <= pwdata[0];
            vqm_pkg::REG_MAX_LEN: cfg_ff.max_buffer_len   <= pwdata[vqm_pkg::LEN_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      prdata = '0;
      unique case (reg_sel)
         vqm_pkg::REG_MERGE:   prdata = vqm_pkg::DATA_W'(cfg_ff.merge_feature_on);
         vqm_pkg::REG_CHECKS:  prdata = vqm_pkg::DATA_W'(cfg_ff.header_checks_on);
         vqm_pkg::REG_MAX_LEN: prdata = vqm_pkg::DATA_W'(cfg_ff.max_buffer_len);
         default:              prdata = '0;
      endcase
   end

endmodule

>>> hw/rtl/vqm_ctrl.sv
// Command sequencer: accepts a transaction, runs its commit cycle and strobes the result.
`timescale 1ns / 1ps

module vqm_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   output logic                  rsp_valid,
   output vqm_pkg::ctl_cmd_type  cmd
);

   typedef enum logic {
      S_IDLE,
      S_EXEC
   } state_type;

   state_type state_ff;
   logic      rsp_valid_ff;

   assign busy       = (state_ff == S_EXEC);
   assign rsp_valid  = rsp_valid_ff;
   assign cmd.launch = start && (state_ff == S_IDLE);
   assign cmd.commit = (state_ff == S_EXEC);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= (state_ff == S_EXEC);
         unique case (state_ff)
            S_IDLE: begin
               if (start) state_ff <= S_EXEC;
            end
            S_EXEC: state_ff <= S_IDLE;
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   a_accept_then_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("Accepted transaction did not enter its commit cycle.");

   a_busy_one_cycle: assert property (@(posedge clock) disable iff (reset)
      busy |=> (!busy && rsp_valid))
      else $error("Commit cycle did not end with a result strobe.");

endmodule

>>> hw/rtl/vqm_dp.sv
// Datapath: free list, link and tag memories, ring indices and header classification.
`timescale 1ns / 1ps

module vqm_dp (
   input  logic                  clock,
   input  logic                  reset,
   input  vqm_pkg::ctl_cmd_type  cmd,
   input  vqm_pkg::cfg_type      cfg,
   input  vqm_pkg::req_type      req_data,
   output vqm_pkg::rsp_type      rsp_data
);

   localparam int IW = vqm_pkg::IDX_W;

   logic [IW-1:0]                 link_mem [vqm_pkg::RING_SIZE];
   logic [vqm_pkg::TAG_WIDTH-1:0] tag_mem  [vqm_pkg::RING_SIZE];

   logic [vqm_pkg::RING_SIZE-1:0] link_valid_ff;
   logic [vqm_pkg::RING_SIZE-1:0] slot_busy_ff;
   logic [IW-1:0]                 head_ff;
   logic [vqm_pkg::FREE_W-1:0]    free_ff;
   logic [15:0]                   avail_ff;
   logic [15:0]                   used_ff;

   vqm_pkg::req_type              req_ff;
   logic [IW-1:0]                 link_rd_ff;
   logic                          link_vld_rd_ff;
   logic [vqm_pkg::TAG_WIDTH-1:0] tag_rd_ff;
   vqm_pkg::rsp_type              rsp_ff;

   logic [IW-1:0]                 link_eff;
   logic [IW-1:0]                 cid;
   logic                          is_post;
   logic                          post_ok;
   logic                          done_ok;
   vqm_pkg::rsp_type              rsp_in;
   vqm_pkg::status_type           chk_status;

   assign rsp_data = rsp_ff;
   assign cid      = req_ff.used_id[IW-1:0];
   assign is_post  = (req_ff.command == vqm_pkg::CMD_POST);
   assign link_eff = link_vld_rd_ff ? link_rd_ff : IW'(head_ff + 1'b1);
   assign post_ok  = is_post && (free_ff != '0);
   assign done_ok  = !is_post && slot_busy_ff[cid];

   always_ff @(posedge clock) begin
      if (cmd.launch) begin
         req_ff         <= req_data;
         link_rd_ff     <= link_mem[head_ff];
         link_vld_rd_ff <= link_valid_ff[head_ff];
         tag_rd_ff      <= tag_mem[req_data.used_id[IW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         if (post_ok) tag_mem[head_ff] <= req_ff.buffer_tag;
         if (done_ok) link_mem[cid] <= head_ff;
      end
   end

   always_comb begin
      priority if (req_ff.used_len < vqm_pkg::HDR_BYTES) chk_status = vqm_pkg::ST_SHORT;
      else if (req_ff.seg_kind != '0)                     chk_status = vqm_pkg::ST_GSO;
      else if (req_ff.header_flags[0])                    chk_status = vqm_pkg::ST_CSUM;
      else if (cfg.merge_feature_on && (req_ff.buffer_count > vqm_pkg::CNT_W'(1)))
                                                          chk_status = vqm_pkg::ST_MERGED;
      else if (req_ff.used_len > cfg.max_buffer_len)      chk_status = vqm_pkg::ST_OVERSIZE;
      else                                                chk_status = vqm_pkg::ST_OK;
   end

   always_comb begin
      rsp_in             = '0;
      rsp_in.avail_count = avail_ff;
      rsp_in.used_count  = used_ff;
      rsp_in.free_left   = free_ff;
      if (is_post) begin
         if (post_ok) begin
            rsp_in.status      = vqm_pkg::ST_OK;
            rsp_in.desc_index  = 7'(head_ff);
            rsp_in.desc_len    = req_ff.post_len;
            rsp_in.ring_slot   = 7'(avail_ff[IW-1:0]);
            rsp_in.avail_count = avail_ff + 16'd1;
            rsp_in.free_left   = free_ff - 1'b1;
         end else begin
            rsp_in.status = vqm_pkg::ST_RING_FULL;
         end
      end else begin
         rsp_in.desc_index = req_ff.used_id;
         rsp_in.used_count = used_ff + 16'd1;
         if (done_ok) begin
            rsp_in.tag_out   = 16'(tag_rd_ff);
            rsp_in.free_left = free_ff + 1'b1;
            if (cfg.header_checks_on) begin
               rsp_in.status = chk_status;
               if (chk_status == vqm_pkg::ST_OK)
                  rsp_in.payload_len = req_ff.used_len - vqm_pkg::HDR_BYTES;
            end else begin
               rsp_in.status = vqm_pkg::ST_OK;
            end
         end else begin
            rsp_in.status = vqm_pkg::ST_EMPTY;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         link_valid_ff <= '0;
         slot_busy_ff  <= '0;
         head_ff       <= '0;
         free_ff       <= vqm_pkg::FREE_RESET;
         avail_ff      <= '0;
         used_ff       <= '0;
      end else if (cmd.commit) begin
         avail_ff <= rsp_in.avail_count;
         used_ff  <= rsp_in.used_count;
         free_ff  <= rsp_in.free_left;
         if (post_ok) begin
            slot_busy_ff[head_ff] <= 1'b1;
            head_ff               <= link_eff;
         end
         if (done_ok) begin
            slot_busy_ff[cid]  <= 1'b0;
            link_valid_ff[cid] <= 1'b1;
            head_ff            <= cid;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) rsp_ff <= rsp_in;
   end

   a_free_bound: assert property (@(posedge clock) disable iff (reset)
      free_ff <= vqm_pkg::FREE_RESET)
      else $error("Free descriptor count exceeds the ring size.");

   a_post_pops_one: assert property (@(posedge clock) disable iff (reset)
      (cmd.commit && post_ok) |=> (free_ff == $past(free_ff) - 1'b1)
         && slot_busy_ff[$past(head_ff)])
      else $error("Successful post did not take exactly one free descriptor.");

endmodule
